FILE: rtl/core/dcts_pkg.sv
package dcts_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_LIST   = 2'd2;
    localparam logic [1:0] REQ_STATUS = 2'd3;

    // step states as stored in the table
    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_FAILED   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_BAD      = 2'd3;

    // one table entry
    typedef struct packed {
        logic [31:0] mask;
        logic [5:0]  cnt;
        logic [2:0]  st;
    } entry_t;

    // population count of one byte
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/dependency_count_task_scheduler.sv
// Build-step scheduler with dependency counting. Steps are appended by add
// requests and moved through pending, ready, running and finished or failed
// by update requests; finishing a step walks the table and releases every
// dependent whose count drops to zero. The whole table (state, count, mask)
// lives in one RAM with a single read and a single write port, and one
// request is handled at a time. Finishing updates and ready lists walk the
// table one entry per cycle through the read port, a ready list except while
// a found step waits for a stalled output register. The table needs no
// clearing after reset: only entries below the step count are ever read.
// Results go out through an output register, so a new request is taken
// while the last result of the previous one still waits.
module dependency_count_task_scheduler
    import dcts_pkg::*;
#(
    parameter int MAX_STEPS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [4:0]  target_step,
    input  logic [31:0] dependency_mask,
    input  logic [2:0]  new_state,
    input  logic [5:0]  max_count,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [4:0]  step_index,
    output logic        found,
    output logic [1:0]  status,
    output logic [2:0]  observed_state,
    output logic [5:0]  total_steps,
    output logic [5:0]  remaining_steps,
    output logic        is_built,
    output logic        last
);

    localparam int CAP = (MAX_STEPS < 32) ? MAX_STEPS : 32;
    localparam int IW  = $clog2(CAP);
    localparam int EW  = $bits(entry_t);
    localparam logic [5:0] CAP_W = 6'(CAP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_UPD_CHK,
        S_FIN,
        S_LIST,
        S_EMIT
    } fsm_t;

    fsm_t        state_reg, state_next;
    logic [1:0]  rq_type_reg, rq_type_next;
    logic [4:0]  rq_target_reg, rq_target_next;
    logic [31:0] rq_mask_reg, rq_mask_next;
    logic [2:0]  rq_want_reg, rq_want_next;
    logic [5:0]  rq_max_reg, rq_max_next;
    logic [5:0]  step_count_reg, step_count_next;
    logic [5:0]  remaining_reg, remaining_next;
    logic [5:0]  nzfin_reg, nzfin_next;
    logic [5:0]  rd_idx_reg, rd_idx_next;
    logic        dvalid_reg, dvalid_next;
    logic [IW-1:0] dat_idx_reg, dat_idx_next;
    logic        held_valid_reg, held_valid_next;
    logic [4:0]  held_idx_reg, held_idx_next;
    logic [5:0]  hit_cnt_reg, hit_cnt_next;
    logic [4:0]  res_idx_reg, res_idx_next;
    logic        res_found_reg, res_found_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [2:0]  res_obs_reg, res_obs_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [4:0]  o_idx_reg, o_idx_next;
    logic        o_found_reg, o_found_next;
    logic [1:0]  o_status_reg, o_status_next;
    logic [2:0]  o_obs_reg, o_obs_next;
    logic [5:0]  o_total_reg, o_total_next;
    logic [5:0]  o_remain_reg, o_remain_next;
    logic        o_built_reg, o_built_next;
    logic        o_last_reg, o_last_next;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [IW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;
    entry_t        rd_entry;
    entry_t        wr_entry;

    logic        out_free;
    logic        out_load;
    logic [4:0]  ld_idx;
    logic        ld_found;
    logic [1:0]  ld_status;
    logic [2:0]  ld_obs;
    logic        ld_last;
    logic [5:0]  add_pop;
    logic        add_full;
    logic        add_bad;
    logic [2:0]  need_st;
    logic        act;
    logic [5:0]  dec_cnt;
    logic        hit;
    logic        nh_valid;
    logic [4:0]  nh_idx;
    logic [6:0]  cnt_inc;
    logic        list_done;

    // step table
    dcts_ram #(
        .WIDTH(EW),
        .DEPTH(CAP)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign rd_entry    = ram_rd_data;
    assign ram_wr_data = wr_entry;

    // handshake and output ports
    assign req_stall       = (state_reg != S_IDLE);
    assign out_free        = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign step_index      = o_idx_reg;
    assign found           = o_found_reg;
    assign status          = o_status_reg;
    assign observed_state  = o_obs_reg;
    assign total_steps     = o_total_reg;
    assign remaining_steps = o_remain_reg;
    assign is_built        = o_built_reg;
    assign last            = o_last_reg;

    // add checks and dependency count of the new step
    assign add_pop = 6'(pop8(rq_mask_reg[7:0])) + 6'(pop8(rq_mask_reg[15:8]))
                   + 6'(pop8(rq_mask_reg[23:16])) + 6'(pop8(rq_mask_reg[31:24]));
    assign add_full = (step_count_reg >= CAP_W);
    assign add_bad  = (step_count_reg < 6'd32) && ((rq_mask_reg >> step_count_reg) != 32'd0);

    // state that an update move requires
    always_comb
    begin
        need_st = ST_PENDING;
        act     = 1'b1;
        case (rq_want_reg) inside
            ST_READY:               need_st = ST_PENDING;
            ST_RUNNING:             need_st = ST_READY;
            ST_FINISHED, ST_FAILED: need_st = ST_RUNNING;
            default:                act     = 1'b0;
        endcase
    end

    // ready list bookkeeping
    assign dec_cnt   = rd_entry.cnt - 6'd1;
    assign hit       = dvalid_reg && (rd_entry.st == ST_READY);
    assign nh_valid  = hit || held_valid_reg;
    assign nh_idx    = hit ? 5'(dat_idx_reg) : held_idx_reg;
    assign cnt_inc   = {1'b0, hit_cnt_reg} + {6'd0, hit};
    assign list_done = (hit && (cnt_inc >= {1'b0, rq_max_reg})) || (rd_idx_reg >= step_count_reg);

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        rq_type_next    = rq_type_reg;
        rq_target_next  = rq_target_reg;
        rq_mask_next    = rq_mask_reg;
        rq_want_next    = rq_want_reg;
        rq_max_next     = rq_max_reg;
        step_count_next = step_count_reg;
        remaining_next  = remaining_reg;
        nzfin_next      = nzfin_reg;
        rd_idx_next     = rd_idx_reg;
        dvalid_next     = dvalid_reg;
        dat_idx_next    = dat_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        res_idx_next    = res_idx_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_obs_next    = res_obs_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        wr_entry        = rd_entry;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        out_load        = 1'b0;
        ld_idx          = 5'd0;
        ld_found        = 1'b0;
        ld_status       = STAT_OK;
        ld_obs          = ST_PENDING;
        ld_last         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_type_next   = req_type;
                    rq_target_next = target_step;
                    rq_mask_next   = dependency_mask;
                    rq_want_next   = new_state;
                    rq_max_next    = max_count;
                    state_next     = S_REQ;
                end
            end

            S_REQ:
            begin
                res_idx_next    = 5'd0;
                res_found_next  = 1'b0;
                res_status_next = STAT_OK;
                res_obs_next    = ST_PENDING;
                state_next      = S_EMIT;
                case (rq_type_reg)
                    REQ_ADD:
                    begin
                        if (add_full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else if (add_bad)
                        begin
                            res_status_next = STAT_BAD;
                        end
                        else
                        begin
                            ram_wr_en       = 1'b1;
                            ram_wr_addr     = step_count_reg[IW-1:0];
                            wr_entry.mask   = rq_mask_reg;
                            wr_entry.cnt    = add_pop;
                            wr_entry.st     = (rq_mask_reg == 32'd0) ? ST_READY : ST_PENDING;
                            step_count_next = step_count_reg + 6'd1;
                            remaining_next  = remaining_reg + 6'd1;
                            res_idx_next    = step_count_reg[4:0];
                            res_found_next  = 1'b1;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if ({1'b0, rq_target_reg} >= step_count_reg)
                        begin
                            res_status_next = STAT_BAD;
                        end
                        else if (act)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = rq_target_reg[IW-1:0];
                            state_next  = S_UPD_CHK;
                        end
                    end
                    REQ_LIST:
                    begin
                        if (rq_max_reg != 6'd0)
                        begin
                            rd_idx_next     = 6'd0;
                            dvalid_next     = 1'b0;
                            held_valid_next = 1'b0;
                            hit_cnt_next    = 6'd0;
                            state_next      = S_LIST;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_UPD_CHK:
            begin
                if (rd_entry.st != need_st)
                begin
                    res_status_next = STAT_MISMATCH;
                    res_obs_next    = rd_entry.st;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = rq_target_reg[IW-1:0];
                    wr_entry.st = rq_want_reg;
                    if (rq_want_reg == ST_FINISHED)
                    begin
                        remaining_next = remaining_reg - 6'd1;
                        if (rd_entry.cnt != 6'd0)
                        begin
                            nzfin_next = nzfin_reg + 6'd1;
                        end
                        rd_idx_next = 6'd0;
                        dvalid_next = 1'b0;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_FIN:
            begin
                // write back the entry read last cycle
                if (dvalid_reg && rd_entry.mask[rq_target_reg] && (rd_entry.cnt != 6'd0))
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = dat_idx_reg;
                    wr_entry.cnt = dec_cnt;
                    if (dec_cnt == 6'd0)
                    begin
                        if (rd_entry.st == ST_PENDING)
                        begin
                            wr_entry.st = ST_READY;
                        end
                        if (rd_entry.st == ST_FINISHED)
                        begin
                            nzfin_next = nzfin_reg - 6'd1;
                        end
                    end
                end
                // read the next entry
                if (rd_idx_reg < step_count_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = rd_idx_reg[IW-1:0];
                    dat_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + 6'd1;
                    dvalid_next  = 1'b1;
                end
                else
                begin
                    dvalid_next = 1'b0;
                    state_next  = S_EMIT;
                end
            end

            S_LIST:
            begin
                // a new hit while one is held needs a free output register
                if (!(hit && held_valid_reg && !out_free))
                begin
                    if (hit && held_valid_reg)
                    begin
                        out_load = 1'b1;
                        ld_idx   = held_idx_reg;
                        ld_found = 1'b1;
                    end
                    hit_cnt_next = cnt_inc[5:0];
                    if (list_done)
                    begin
                        res_idx_next    = nh_valid ? nh_idx : 5'd0;
                        res_found_next  = nh_valid;
                        held_valid_next = 1'b0;
                        dvalid_next     = 1'b0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        ram_rd_en       = 1'b1;
                        ram_rd_addr     = rd_idx_reg[IW-1:0];
                        dat_idx_next    = rd_idx_reg[IW-1:0];
                        rd_idx_next     = rd_idx_reg + 6'd1;
                        dvalid_next     = 1'b1;
                        held_valid_next = nh_valid;
                        held_idx_next   = nh_idx;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_idx     = res_idx_reg;
                    ld_found   = res_found_reg;
                    ld_status  = res_status_reg;
                    ld_obs     = res_obs_reg;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        o_idx_next     = o_idx_reg;
        o_found_next   = o_found_reg;
        o_status_next  = o_status_reg;
        o_obs_next     = o_obs_reg;
        o_total_next   = o_total_reg;
        o_remain_next  = o_remain_reg;
        o_built_next   = o_built_reg;
        o_last_next    = o_last_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            o_idx_next     = ld_idx;
            o_found_next   = ld_found;
            o_status_next  = ld_status;
            o_obs_next     = ld_obs;
            o_total_next   = step_count_reg;
            o_remain_next  = remaining_reg;
            o_built_next   = (remaining_reg == 6'd0) && (nzfin_reg == 6'd0);
            o_last_next    = ld_last;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rq_type_reg    <= REQ_ADD;
            rq_target_reg  <= 5'd0;
            rq_mask_reg    <= 32'd0;
            rq_want_reg    <= ST_PENDING;
            rq_max_reg     <= 6'd0;
            step_count_reg <= 6'd0;
            remaining_reg  <= 6'd0;
            nzfin_reg      <= 6'd0;
            rd_idx_reg     <= 6'd0;
            dvalid_reg     <= 1'b0;
            dat_idx_reg    <= '0;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= 5'd0;
            hit_cnt_reg    <= 6'd0;
            res_idx_reg    <= 5'd0;
            res_found_reg  <= 1'b0;
            res_status_reg <= STAT_OK;
            res_obs_reg    <= ST_PENDING;
            rsp_valid_reg  <= 1'b0;
            o_idx_reg      <= 5'd0;
            o_found_reg    <= 1'b0;
            o_status_reg   <= STAT_OK;
            o_obs_reg      <= ST_PENDING;
            o_total_reg    <= 6'd0;
            o_remain_reg   <= 6'd0;
            o_built_reg    <= 1'b0;
            o_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rq_type_reg    <= rq_type_next;
            rq_target_reg  <= rq_target_next;
            rq_mask_reg    <= rq_mask_next;
            rq_want_reg    <= rq_want_next;
            rq_max_reg     <= rq_max_next;
            step_count_reg <= step_count_next;
            remaining_reg  <= remaining_next;
            nzfin_reg      <= nzfin_next;
            rd_idx_reg     <= rd_idx_next;
            dvalid_reg     <= dvalid_next;
            dat_idx_reg    <= dat_idx_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            hit_cnt_reg    <= hit_cnt_next;
            res_idx_reg    <= res_idx_next;
            res_found_reg  <= res_found_next;
            res_status_reg <= res_status_next;
            res_obs_reg    <= res_obs_next;
            rsp_valid_reg  <= rsp_valid_next;
            o_idx_reg      <= o_idx_next;
            o_found_reg    <= o_found_next;
            o_status_reg   <= o_status_next;
            o_obs_reg      <= o_obs_next;
            o_total_reg    <= o_total_next;
            o_remain_reg   <= o_remain_next;
            o_built_reg    <= o_built_next;
            o_last_reg     <= o_last_next;
        end
    end

    // step count only grows, one step at a time
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (step_count_reg != $past(step_count_reg))
            |-> (step_count_reg == $past(step_count_reg) + 6'd1))
        else $error("step count moved by other than one");

    // unfinished and finished-with-count tallies stay within the table
    a_tallies: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg <= step_count_reg)
            && (nzfin_reg <= step_count_reg - remaining_reg))
        else $error("step tallies out of range");

    // a stalled result keeps valid and its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall)
            |=> (rsp_valid && $stable({step_index, found, status, observed_state,
                                       total_steps, remaining_steps, is_built, last})))
        else $error("stalled result changed");

endmodule

FILE: rtl/core/dcts_ram.sv
module dcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port that holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: dv/dependency_count_task_scheduler_tb.sv
`timescale 1ns / 100ps

module dependency_count_task_scheduler_tb;
    import dcts_pkg::*;

    localparam int TABLE_CAP     = 32;
    localparam int RANDOM_ITEMS  = 380;
    localparam int QUIET_ITEMS   = 60;
    localparam int DRAIN_CYCLES  = 48;
    localparam int CYCLE_LIMIT   = 400000;

    // one request as it goes over the request channel
    typedef struct {
        logic [1:0]  rtype;
        logic [4:0]  target;
        logic [31:0] mask;
        logic [2:0]  want;
        logic [5:0]  max_cnt;
    } step_req_t;

    // one result item
    typedef struct packed {
        logic [4:0] idx;
        logic       found;
        logic [1:0] status;
        logic [2:0] observed;
        logic [5:0] total;
        logic [5:0] remaining;
        logic       built;
        logic       last;
    } step_rsp_t;

    // directed row, with an optional typed-in expectation
    typedef struct {
        step_req_t rq;
        bit        typed;
        step_rsp_t exp;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [4:0]  target_step;
    logic [31:0] dependency_mask;
    logic [2:0]  new_state;
    logic [5:0]  max_count;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [4:0]  step_index;
    logic        found;
    logic [1:0]  status;
    logic [2:0]  observed_state;
    logic [5:0]  total_steps;
    logic [5:0]  remaining_steps;
    logic        is_built;
    logic        last;

    // scheduler table as the testbench predicts it
    logic [5:0]  sched_steps;
    logic [2:0]  sched_state [TABLE_CAP];
    logic [5:0]  sched_cnt [TABLE_CAP];
    logic [31:0] sched_mask [TABLE_CAP];

    step_rsp_t   pending_rsp_q [$];
    script_row_t script_q [$];
    step_rsp_t   seen_rsp;
    step_rsp_t   want_rsp;

    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int unsigned idle_pct;
    int unsigned stall_left = 0;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned steps_finished;
    int unsigned steps_released;
    int unsigned full_rejects;

    dependency_count_task_scheduler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .target_step     (target_step),
        .dependency_mask (dependency_mask),
        .new_state       (new_state),
        .max_count       (max_count),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .step_index      (step_index),
        .found           (found),
        .status          (status),
        .observed_state  (observed_state),
        .total_steps     (total_steps),
        .remaining_steps (remaining_steps),
        .is_built        (is_built),
        .last            (last)
    );

    // clock
    always #5 clk = ~clk;

    // append one expected result to the queue
    function automatic void add_expected(input step_rsp_t r);
        pending_rsp_q.insert(pending_rsp_q.size(), r);
    endfunction

    // result item carrying the table totals as they stand now
    function automatic step_rsp_t table_rsp(input logic [4:0] idx, input logic fnd,
                                            input logic [1:0] stat, input logic [2:0] obs);
        step_rsp_t r;
        logic [5:0] rem;
        logic       blt;
        rem = '0;
        blt = 1'b1;
        for (int i = 0; i < sched_steps; i++)
        begin
            if (sched_state[i] != ST_FINISHED)
                rem = rem + 6'd1;
            if (sched_state[i] != ST_FINISHED || sched_cnt[i] != '0)
                blt = 1'b0;
        end
        r.idx       = idx;
        r.found     = fnd;
        r.status    = stat;
        r.observed  = obs;
        r.total     = sched_steps;
        r.remaining = rem;
        r.built     = blt;
        r.last      = 1'b0;
        return r;
    endfunction

    // apply one request to the predicted table and queue the results it causes
    task automatic schedule_request(input step_req_t r);
        int        first;
        int        slot;
        logic [2:0] need;
        logic      acts;
        logic [5:0] deps;
        first = pending_rsp_q.size();
        need  = ST_PENDING;
        acts  = 1'b1;
        case (r.rtype)
            REQ_ADD:
            begin
                if (sched_steps >= TABLE_CAP)
                begin
                    full_rejects++;
                    add_expected(table_rsp('0, 1'b0, STAT_FULL, '0));
                end
                else if ((r.mask >> sched_steps) != '0)
                    add_expected(table_rsp('0, 1'b0, STAT_BAD, '0));
                else
                begin
                    slot = sched_steps;
                    deps = '0;
                    for (int j = 0; j < 32; j++)
                        deps = deps + {5'd0, r.mask[j]};
                    sched_mask[slot]  = r.mask;
                    sched_cnt[slot]   = deps;
                    sched_state[slot] = (r.mask == '0) ? ST_READY : ST_PENDING;
                    sched_steps = sched_steps + 6'd1;
                    add_expected(table_rsp(slot[4:0], 1'b1, STAT_OK, '0));
                end
            end
            REQ_UPDATE:
            begin
                if ({1'b0, r.target} >= sched_steps)
                    add_expected(table_rsp('0, 1'b0, STAT_BAD, '0));
                else
                begin
                    case (r.want)
                        ST_READY:    need = ST_PENDING;
                        ST_RUNNING:  need = ST_READY;
                        ST_FINISHED: need = ST_RUNNING;
                        ST_FAILED:   need = ST_RUNNING;
                        default:     acts = 1'b0;
                    endcase
                    if (!acts)
                        add_expected(table_rsp('0, 1'b0, STAT_OK, '0));
                    else if (sched_state[r.target] != need)
                        add_expected(table_rsp('0, 1'b0, STAT_MISMATCH,
                                               sched_state[r.target]));
                    else
                    begin
                        sched_state[r.target] = r.want;
                        // finishing releases every dependent whose count drops to zero
                        if (r.want == ST_FINISHED)
                        begin
                            steps_finished++;
                            for (int j = 0; j < sched_steps; j++)
                            begin
                                if (sched_mask[j][r.target] && sched_cnt[j] != '0)
                                begin
                                    sched_cnt[j] = sched_cnt[j] - 6'd1;
                                    if (sched_cnt[j] == '0 && sched_state[j] == ST_PENDING)
                                    begin
                                        sched_state[j] = ST_READY;
                                        steps_released++;
                                    end
                                end
                            end
                        end
                        add_expected(table_rsp('0, 1'b0, STAT_OK, '0));
                    end
                end
            end
            REQ_LIST:
            begin
                for (int i = 0; i < sched_steps; i++)
                begin
                    if (pending_rsp_q.size() - first >= r.max_cnt)
                        break;
                    if (sched_state[i] == ST_READY)
                        add_expected(table_rsp(i[4:0], 1'b1, STAT_OK, '0));
                end
                if (pending_rsp_q.size() == first)
                    add_expected(table_rsp('0, 1'b0, STAT_OK, '0));
            end
            default:
                add_expected(table_rsp('0, 1'b0, STAT_OK, '0));
        endcase
        pending_rsp_q[pending_rsp_q.size() - 1].last = 1'b1;
    endtask

    // one request transfer, with an optional gap before it
    task automatic send_request(input step_req_t r, input bit typed, input step_rsp_t typed_rsp);
        int unsigned gap;
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        req_valid       <= 1'b1;
        req_type        <= r.rtype;
        target_step     <= r.target;
        dependency_mask <= r.mask;
        new_state       <= r.want;
        max_count       <= r.max_cnt;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        schedule_request(r);
        // rows with a typed-in result replace the predicted one
        if (typed)
            pending_rsp_q[pending_rsp_q.size() - 1] = typed_rsp;
        requests_sent++;
    endtask

    // directed row builder; typed results are single, unlisted items
    task automatic script_row(input logic [1:0] rt, input int tgt, input logic [31:0] m,
                              input logic [2:0] w, input int mc, input bit typed,
                              input logic [1:0] st, input int tot, input int rem,
                              input logic blt);
        script_row_t row;
        row.rq.rtype      = rt;
        row.rq.target     = tgt[4:0];
        row.rq.mask       = m;
        row.rq.want       = w;
        row.rq.max_cnt    = mc[5:0];
        row.typed         = typed;
        row.exp.idx       = '0;
        row.exp.found     = 1'b0;
        row.exp.status    = st;
        row.exp.observed  = '0;
        row.exp.total     = tot[5:0];
        row.exp.remaining = rem[5:0];
        row.exp.built     = blt;
        row.exp.last      = 1'b1;
        script_q.insert(script_q.size(), row);
    endtask

    // random request shaped by the predicted table: mostly legal life-cycle moves
    task automatic pick_request(output step_req_t r);
        int unsigned dice;
        int unsigned t;
        int unsigned tries;
        dice      = $urandom_range(0, 99);
        r.rtype   = REQ_STATUS;
        r.target  = 5'($urandom_range(0, 31));
        r.mask    = $urandom;
        r.want    = 3'($urandom_range(0, 7));
        r.max_cnt = 6'($urandom_range(0, 32));
        if (dice < 25)
        begin
            r.rtype = REQ_ADD;
            // sparse masks over existing steps, now and then raw noise
            if ($urandom_range(0, 9) != 0)
            begin
                r.mask = '0;
                if (sched_steps != '0)
                    repeat ($urandom_range(0, 3))
                        r.mask[$urandom_range(0, sched_steps - 1)] = 1'b1;
            end
        end
        else if (dice < 75)
        begin
            r.rtype = REQ_UPDATE;
            if (sched_steps != '0 && $urandom_range(0, 6) != 0)
            begin
                // look for a step that can move forward
                t = $urandom_range(0, sched_steps - 1);
                tries = 0;
                while (tries < 4 && sched_state[t] != ST_READY && sched_state[t] != ST_RUNNING)
                begin
                    t = $urandom_range(0, sched_steps - 1);
                    tries++;
                end
                r.target = t[4:0];
                case (sched_state[t])
                    ST_PENDING: r.want = ST_READY;
                    ST_READY:   r.want = ST_RUNNING;
                    ST_RUNNING: r.want = ($urandom_range(0, 7) == 0) ? ST_FAILED : ST_FINISHED;
                    default:    r.want = 3'($urandom_range(0, 7));
                endcase
            end
        end
        else if (dice < 90)
        begin
            r.rtype = REQ_LIST;
            if ($urandom_range(0, 1) == 0)
                r.max_cnt = 6'd32;
        end
    endtask

    // one result item as text
    function automatic string rsp_text(input step_rsp_t r);
        return {$sformatf("idx=%0d found=%0d status=%0d obs=%0d", r.idx, r.found, r.status,
                          r.observed),
                $sformatf(" total=%0d rem=%0d built=%0d last=%0d", r.total, r.remaining,
                          r.built, r.last)};
    endfunction

    task automatic report_mismatch(input string what, input step_rsp_t exp, input step_rsp_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: exp %s | got %s", what, rsp_text(exp), rsp_text(got));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            seen_rsp.idx       = step_index;
            seen_rsp.found     = found;
            seen_rsp.status    = status;
            seen_rsp.observed  = observed_state;
            seen_rsp.total     = total_steps;
            seen_rsp.remaining = remaining_steps;
            seen_rsp.built     = is_built;
            seen_rsp.last      = last;
            if (pending_rsp_q.size() == 0)
                report_mismatch("unexpected result", '0, seen_rsp);
            else
            begin
                want_rsp = pending_rsp_q.pop_front();
                results_checked++;
                if (seen_rsp !== want_rsp)
                    report_mismatch("result mismatch", want_rsp, seen_rsp);
            end
        end
    end

    // result-side stall in short random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
            rsp_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        step_req_t rq;
        step_rsp_t none;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req_type        = REQ_STATUS;
        target_step     = '0;
        dependency_mask = '0;
        new_state       = ST_PENDING;
        max_count       = '0;
        none            = '0;
        fail_count      = 0;
        idle_pct        = 20;
        requests_sent   = 0;
        results_checked = 0;
        steps_finished  = 0;
        steps_released  = 0;
        full_rejects    = 0;
        sched_steps     = '0;
        for (int i = 0; i < TABLE_CAP; i++)
        begin
            sched_state[i] = ST_PENDING;
            sched_cnt[i]   = '0;
            sched_mask[i]  = '0;
        end

        // empty table, errors on it, then a small hand-built graph
        script_row(REQ_STATUS, 0, '0, ST_PENDING, 0, 1, STAT_OK, 0, 0, 1'b1);
        script_row(REQ_LIST, 0, '0, ST_PENDING, 32, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 0, '0, ST_READY, 0, 1, STAT_BAD, 0, 0, 1'b1);
        script_row(REQ_ADD, 0, 32'hFFFF_FFFF, ST_PENDING, 0, 1, STAT_BAD, 0, 0, 1'b1);
        script_row(REQ_ADD, 0, 32'h0, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 0, '0, ST_RUNNING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 0, '0, ST_FINISHED, 0, 0, STAT_OK, 0, 0, 1'b0);
        // step 1 waits on a step that is already finished
        script_row(REQ_ADD, 0, 32'h1, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_ADD, 0, 32'h0, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_ADD, 0, 32'h2, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_ADD, 0, 32'h6, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, ST_RUNNING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, ST_READY, 0, 0, STAT_OK, 0, 0, 1'b0);
        // step 3 moved by hand before its dependency finishes
        script_row(REQ_UPDATE, 3, '0, ST_READY, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, 3'd7, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_LIST, 0, '0, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_LIST, 0, '0, ST_PENDING, 1, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_LIST, 0, '0, ST_PENDING, 32, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, ST_RUNNING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 1, '0, ST_FINISHED, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 2, '0, ST_RUNNING, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 2, '0, ST_FAILED, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 2, '0, ST_FINISHED, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_UPDATE, 31, '0, ST_FINISHED, 0, 0, STAT_OK, 0, 0, 1'b0);
        script_row(REQ_ADD, 0, 32'h8000_0000, ST_PENDING, 0, 0, STAT_OK, 0, 0, 1'b0);

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        foreach (script_q[i])
            send_request(script_q[i].rq, script_q[i].typed, script_q[i].exp);

        // random part, idle level changes by phase and is off at the end
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_pct = 0;
            else if (k % 50 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            pick_request(rq);
            send_request(rq, 1'b0, none);
        end

        // drain
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d results checked, %0d steps in table",
                 requests_sent, results_checked, sched_steps);
        $display("summary: %0d steps finished, %0d released by count, %0d full-table rejects",
                 steps_finished, steps_released, full_rejects);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
